>>> hw/rtl/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
package ffha_pkg;

    localparam int HEAP_WORDS_DEFAULT = 4096;

    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_ASSIGNED = 2'd1;
    localparam logic [1:0] ST_FREED    = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] CFG_HEAP_BASE   = 2'd0;
    localparam logic [1:0] CFG_HEAP_BYTES  = 2'd1;
    localparam logic [1:0] CFG_GUARD_BYTES = 2'd2;

    localparam logic [31:0] HEAP_BASE_RESET   = 32'h0000_0000;
    localparam logic [14:0] HEAP_BYTES_RESET  = 15'd16384;
    localparam logic [14:0] GUARD_BYTES_RESET = 15'd1024;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] size;
    } hdr_t;

endpackage

>>> hw/rtl/first_fit_heap_allocator.sv
// First-fit heap allocator with block headers kept in one synchronous header memory.
// After reset the block sweeps all HEAP_WORDS header words to zero and holds s_tready low
// meanwhile; configuration writes are taken at any time. A free request goes through
// S_FCHECK, S_FUPDATE and S_RESULT, or through S_FCHECK and S_RESULT when its address is
// rejected without a header read. An allocate request walks the headers (none on an empty
// heap) and reuses the first freed one that is large enough, or else goes to S_APPEND,
// which appends or fails, and then to S_RESULT. Each header read takes a read issue state
// and a check state because the header memory read is registered. A request stays in
// S_RESULT while the output register is full and not taken. One request is in work at a
// time; a finished result waits in the output register while the next request is accepted.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_WORDS = HEAP_WORDS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [14:0] request_bytes, [46:15] address, [47] zero
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] block_address, [32] ok, [39:33] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW  = $clog2(HEAP_WORDS);
    localparam int BW  = AW + 1;
    localparam int NXW = ((BW > 15) ? BW : 15) + 1;
    localparam int EW  = ((BW > 14) ? BW : 14) + 1;
    localparam int GW  = ((AW + 3) > 16) ? (AW + 3) : 16;
    localparam logic [GW-1:0] CAP_BYTES = GW'(HEAP_WORDS * 4);

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_WISSUE  = 8'b0000_0100,
        S_WCHECK  = 8'b0000_1000,
        S_APPEND  = 8'b0001_0000,
        S_FCHECK  = 8'b0010_0000,
        S_FUPDATE = 8'b0100_0000,
        S_RESULT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0]   heap_base_reg;
    logic [14:0]   heap_bytes_reg;
    logic [14:0]   guard_bytes_reg;
    logic [GW-1:0] limit_reg;

    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [BW-1:0] bump_reg, bump_next;
    logic [BW-1:0] walk_reg, walk_next;
    logic [13:0]   words_reg, words_next;
    logic [31:0]   off_reg, off_next;
    logic          null_reg, null_next;
    logic [31:0]   res_addr_reg, res_addr_next;
    logic          res_ok_reg, res_ok_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [31:0]   m_addr_reg, m_addr_next;
    logic          m_ok_reg, m_ok_next;

    hdr_t          hdr_mem [HEAP_WORDS];
    hdr_t          rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    hdr_t          mem_wdata;

    logic [GW-1:0] total_bytes;
    logic [15:0]   req_round;
    logic [29:0]   free_word;
    logic          free_valid;
    logic [NXW-1:0] walk_step;
    logic [EW-1:0] end_word;
    logic          append_fail;
    logic [31:0]   pay_walk;
    logic [31:0]   pay_bump;
    logic          accept;
    logic          out_free;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'd0, m_ok_reg, m_addr_reg};
    assign out_free  = !m_tvalid_reg || m_tready;

    assign total_bytes = (GW'(heap_bytes_reg) > CAP_BYTES) ? CAP_BYTES : GW'(heap_bytes_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg   <= HEAP_BASE_RESET;
            heap_bytes_reg  <= HEAP_BYTES_RESET;
            guard_bytes_reg <= GUARD_BYTES_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_HEAP_BASE:   heap_base_reg   <= cfg_data;
                CFG_HEAP_BYTES:  heap_bytes_reg  <= cfg_data[14:0];
                CFG_GUARD_BYTES: guard_bytes_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (GW'(guard_bytes_reg) >= total_bytes) begin
            limit_reg <= '0;
        end else begin
            limit_reg <= total_bytes - GW'(guard_bytes_reg);
        end
    end

    assign req_round  = ({1'b0, s_tdata[14:0]} + 16'd3);
    assign free_word  = off_reg[31:2] - 30'd2;
    assign free_valid = !null_reg && (off_reg >= 32'd8) && (off_reg[1:0] == 2'b00)
                        && (free_word < 30'(HEAP_WORDS));
    assign walk_step  = NXW'(walk_reg) + NXW'(2) + NXW'(rd_data_reg.size);
    assign end_word   = EW'(bump_reg) + EW'(2) + EW'(words_reg);
    assign append_fail = ((32'(end_word) << 2) >= 32'(limit_reg))
                         || (bump_reg >= BW'(HEAP_WORDS));
    assign pay_walk   = heap_base_reg + (32'(BW'(walk_reg) + BW'(2)) << 2);
    assign pay_bump   = heap_base_reg + (32'(BW'(bump_reg) + BW'(2)) << 2);

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        bump_next     = bump_reg;
        walk_next     = walk_reg;
        words_next    = words_reg;
        off_next      = off_reg;
        null_next     = null_reg;
        res_addr_next = res_addr_reg;
        res_ok_next   = res_ok_reg;
        m_tvalid_next = m_tvalid_reg;
        m_addr_next   = m_addr_reg;
        m_ok_next     = m_ok_reg;
        rd_addr       = walk_reg[AW-1:0];
        mem_we        = 1'b0;
        mem_waddr     = walk_reg[AW-1:0];
        mem_wdata     = rd_data_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '{status: ST_NONE, size: 15'd0};
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(HEAP_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    words_next = req_round[15:2];
                    off_next   = s_tdata[46:15] - heap_base_reg;
                    null_next  = (s_tdata[46:15] == 32'd0);
                    walk_next  = '0;
                    if (s_tuser == KIND_FREE) begin
                        state_next = S_FCHECK;
                    end else if (bump_reg == '0) begin
                        state_next = S_APPEND;
                    end else begin
                        state_next = S_WISSUE;
                    end
                end
            end
            S_WISSUE: begin
                rd_addr    = walk_reg[AW-1:0];
                state_next = S_WCHECK;
            end
            S_WCHECK: begin
                if (rd_data_reg.status == ST_FREED && rd_data_reg.size >= {1'b0, words_reg}) begin
                    mem_we        = 1'b1;
                    mem_waddr     = walk_reg[AW-1:0];
                    mem_wdata     = '{status: ST_ASSIGNED, size: rd_data_reg.size};
                    res_addr_next = pay_walk;
                    res_ok_next   = 1'b1;
                    state_next    = S_RESULT;
                end else if (walk_step >= NXW'(bump_reg)) begin
                    state_next = S_APPEND;
                end else begin
                    walk_next  = walk_step[BW-1:0];
                    state_next = S_WISSUE;
                end
            end
            S_APPEND: begin
                if (append_fail) begin
                    res_addr_next = 32'd0;
                    res_ok_next   = 1'b0;
                end else begin
                    mem_we        = 1'b1;
                    mem_waddr     = bump_reg[AW-1:0];
                    mem_wdata     = '{status: ST_ASSIGNED, size: 15'(words_reg)};
                    res_addr_next = pay_bump;
                    res_ok_next   = 1'b1;
                    bump_next     = end_word[BW-1:0];
                end
                state_next = S_RESULT;
            end
            S_FCHECK: begin
                rd_addr       = free_word[AW-1:0];
                walk_next     = BW'(free_word[AW-1:0]);
                res_addr_next = 32'd0;
                res_ok_next   = 1'b0;
                state_next    = free_valid ? S_FUPDATE : S_RESULT;
            end
            S_FUPDATE: begin
                if (rd_data_reg.status == ST_ASSIGNED) begin
                    mem_we      = 1'b1;
                    mem_waddr   = walk_reg[AW-1:0];
                    mem_wdata   = '{status: ST_FREED, size: rd_data_reg.size};
                    res_ok_next = 1'b1;
                end
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_addr_next   = res_addr_reg;
                    m_ok_next     = res_ok_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hdr_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= hdr_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            bump_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            bump_reg     <= bump_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_reg     <= walk_next;
        words_reg    <= words_next;
        off_reg      <= off_next;
        null_reg     <= null_next;
        res_addr_reg <= res_addr_next;
        res_ok_reg   <= res_ok_next;
        m_addr_reg   <= m_addr_next;
        m_ok_reg     <= m_ok_next;
    end

    // Only one request is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("request accepted while another is in work");

    // The bump pointer moves only on a successful append.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_APPEND) |=> (bump_reg == $past(bump_reg)))
        else $error("bump pointer moved outside an append");

    // A new result appears only out of the result state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid_reg || m_tready) && (state_reg != S_RESULT) |=> !m_tvalid_reg)
        else $error("result presented without a finished request");

    // A reuse during the walk rewrites only a freed header.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WCHECK) && mem_we |-> (rd_data_reg.status == ST_FREED))
        else $error("walk rewrote a header that was not freed");

    // Frees never touch the bump pointer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FUPDATE) |=> (bump_reg == $past(bump_reg)))
        else $error("free changed the bump pointer");

endmodule
